// File: hw/rtl/gsc_pkg.sv
// shared types and constants of the grid square clearance block
`default_nettype none

package gsc_pkg;

  // fixed field widths
  localparam int COORD_W     = 6;
  localparam int CFG_W       = 7;
  localparam int CLEAR_W     = 4;
  localparam int CLEAR_SAT   = 15;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  // engine status toward the top level
  typedef struct packed {
    logic busy;
    logic res_valid;
  } eng_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/gsc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module gsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gsc_engine.sv
// map access and clearance search sequencer
`default_nettype none

module gsc_engine import gsc_pkg::*; #(
  parameter int GRID_SIDE     = 64,
  parameter int MAX_CLEARANCE = 8,
  localparam int AW = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire kind_e              kind_i,
  input  wire logic [COORD_W-1:0] cell_x_i,
  input  wire logic [COORD_W-1:0] cell_y_i,
  input  wire logic               blocked_bit_i,
  input  wire logic [CFG_W-1:0]   grid_width_i,
  input  wire logic [CFG_W-1:0]   grid_height_i,
  output logic                    ram_we_o,
  output logic [AW-1:0]           ram_waddr_o,
  output logic                    ram_wdata_o,
  output logic                    ram_re_o,
  output logic [AW-1:0]           ram_raddr_o,
  input  wire logic               ram_rdata_i,
  input  wire logic               res_ready_i,
  output eng_status_t             status_o,
  output logic [CLEAR_W-1:0]      clearance_o
);

  localparam int CW   = $clog2((1 << COORD_W) + MAX_CLEARANCE);
  localparam int GW   = $clog2(GRID_SIDE + 1);
  localparam int CMPW = (GW > CW) ? GW : CW;
  localparam int CLW  = $clog2(MAX_CLEARANCE + 1);
  localparam int PW   = AW + CW;
  localparam int SW   = CLW + CLEAR_W;

  typedef enum logic [1:0] {
    G_IDLE,
    G_RUN,
    G_DRAIN,
    G_DONE
  } gen_state_e;

  gen_state_e         state_q;
  logic               first_q;
  logic               side_q;
  logic [CLW-1:0]     c_q;
  logic [CLW-1:0]     i_q;
  logic [COORD_W-1:0] bx_q;
  logic [COORD_W-1:0] by_q;
  logic               p_valid_q;
  logic [CLW-1:0]     p_c_q;
  logic               p_closed_q;
  logic               p_read_q;
  logic [CLEAR_W-1:0] result_q;

  logic [CW-1:0]  px;
  logic [CW-1:0]  py;
  logic [CLW-1:0] pval;
  logic           forced;
  logic           p_in;
  logic           hit;
  logic [SW-1:0]  c_ext;
  logic [CLEAR_W-1:0] c_sat;

  function automatic logic in_map(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    logic [CMPW-1:0] xe;
    logic [CMPW-1:0] ye;
    xe = CMPW'(x);
    ye = CMPW'(y);
    return (xe < CMPW'(w)) && (xe < CMPW'(GRID_SIDE)) &&
           (ye < CMPW'(h)) && (ye < CMPW'(GRID_SIDE));
  endfunction

  // column-major layout: x selects the column block, y the entry in it
  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [PW-1:0] p;
    p = PW'(x) * PW'(GRID_SIDE) + PW'(y);
    return p[AW-1:0];
  endfunction

  // next probe of the growing square
  always_comb begin
    px     = CW'(bx_q);
    py     = CW'(by_q);
    pval   = c_q;
    forced = 1'b0;
    if (first_q) begin
      pval = '0;
    end else if (c_q >= CLW'(MAX_CLEARANCE)) begin
      forced = 1'b1;
    end else if (!side_q) begin
      px = CW'(bx_q) + CW'(i_q);
      py = CW'(by_q) + CW'(c_q);
    end else begin
      px = CW'(bx_q) + CW'(c_q);
      py = CW'(by_q) + CW'(i_q);
    end
  end

  assign p_in = in_map(px, py, grid_width_i, grid_height_i);
  assign hit  = p_valid_q && (p_closed_q || (p_read_q && ram_rdata_i));

  assign c_ext = SW'(p_c_q);
  assign c_sat = (c_ext > SW'(CLEAR_SAT)) ? CLEAR_W'(CLEAR_SAT) : c_ext[CLEAR_W-1:0];

  assign ram_re_o    = (state_q == G_RUN) && !hit && !forced && p_in;
  assign ram_raddr_o = addr_of(px, py);

  // map writes go straight through on the accept edge
  assign ram_we_o    = start_i && (kind_i == KIND_WRITE) &&
                       in_map(CW'(cell_x_i), CW'(cell_y_i), grid_width_i, grid_height_i);
  assign ram_waddr_o = addr_of(CW'(cell_x_i), CW'(cell_y_i));
  assign ram_wdata_o = blocked_bit_i;

  assign status_o.busy      = (state_q != G_IDLE);
  assign status_o.res_valid = (state_q == G_DONE);
  assign clearance_o        = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= G_IDLE;
      first_q    <= 1'b0;
      side_q     <= 1'b0;
      c_q        <= '0;
      i_q        <= '0;
      bx_q       <= '0;
      by_q       <= '0;
      p_valid_q  <= 1'b0;
      p_c_q      <= '0;
      p_closed_q <= 1'b0;
      p_read_q   <= 1'b0;
      result_q   <= '0;
    end else begin
      unique case (state_q)
        G_IDLE: begin
          if (start_i && (kind_i == KIND_QUERY)) begin
            bx_q      <= cell_x_i;
            by_q      <= cell_y_i;
            first_q   <= 1'b1;
            p_valid_q <= 1'b0;
            state_q   <= G_RUN;
          end
        end
        G_RUN: begin
          if (hit) begin
            result_q  <= c_sat;
            p_valid_q <= 1'b0;
            state_q   <= G_DONE;
          end else begin
            p_valid_q  <= 1'b1;
            p_c_q      <= pval;
            p_closed_q <= forced || !p_in;
            p_read_q   <= !forced && p_in;
            if (first_q) begin
              first_q <= 1'b0;
              c_q     <= CLW'(1);
              i_q     <= '0;
              side_q  <= 1'b0;
            end else if (forced) begin
              state_q <= G_DRAIN;
            end else if (side_q) begin
              side_q <= 1'b0;
              if (i_q == c_q) begin
                i_q <= '0;
                c_q <= c_q + CLW'(1);
              end else begin
                i_q <= i_q + CLW'(1);
              end
            end else begin
              side_q <= 1'b1;
            end
          end
        end
        G_DRAIN: begin
          // the forced entry in flight always ends the search
          if (hit) begin
            result_q  <= c_sat;
            p_valid_q <= 1'b0;
            state_q   <= G_DONE;
          end
        end
        G_DONE: begin
          if (res_ready_i) begin
            state_q <= G_IDLE;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/grid_square_clearance.sv
// top level: one-bit blocked map with square clearance queries
// a write item takes effect at its accept edge and gives no result
// a query probes one map cell per cycle, 1 + sum c=1..MAX_CLEARANCE-1 of 2*(c+1) + 1 probes
//   at most, then a drain state; the result waits in the done state until the output stage takes it
// one item at a time, the next one taken the cycle after the result leaves; writes back to back
// reset: a clearing pass frees every cell of the map, no item taken meanwhile
`default_nettype none

module grid_square_clearance import gsc_pkg::*; #(
  parameter int GRID_SIDE     = 64,
  parameter int MAX_CLEARANCE = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input items
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cell_x, cell_y, blocked_bit, zero pad
  input  wire logic                   s_axis_tuser,   // kind
  // result items
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // clearance, zero pad
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic {
    ST_CLEAR,
    ST_READY
  } top_state_e;

  top_state_e          state_q;
  logic [AW-1:0]       clr_cnt_q;
  logic [CFG_W-1:0]    grid_width_q;
  logic [CFG_W-1:0]    grid_height_q;
  logic                out_valid_q;
  logic [CLEAR_W-1:0]  out_clear_q;

  eng_status_t         eng_status;
  logic [CLEAR_W-1:0]  eng_clearance;
  logic                start;
  logic                res_take;

  // engine side of the map
  logic                eng_we;
  logic [AW-1:0]       eng_waddr;
  logic                eng_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic                ram_rdata;

  // muxed write port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_wdata;

  // items wait while the map is cleared or a query runs
  assign s_axis_tready = (state_q == ST_READY) && !eng_status.busy;
  assign start         = s_axis_tvalid && s_axis_tready;

  // result moves into the output stage once that stage is free or drains
  assign res_take      = !out_valid_q || m_axis_tready;

  gsc_engine #(
    .GRID_SIDE     (GRID_SIDE),
    .MAX_CLEARANCE (MAX_CLEARANCE)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_e'(s_axis_tuser)),
    .cell_x_i      (s_axis_tdata[COORD_W-1:0]),
    .cell_y_i      (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .blocked_bit_i (s_axis_tdata[2*COORD_W]),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .ram_we_o      (eng_we),
    .ram_waddr_o   (eng_waddr),
    .ram_wdata_o   (eng_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .res_ready_i   (res_take),
    .status_o      (eng_status),
    .clearance_o   (eng_clearance)
  );

  // clearing pass owns the write port right after reset
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = eng_we;
      ram_waddr = eng_waddr;
      ram_wdata = eng_wdata;
    end
  end

  gsc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // reset sweep over the whole map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= ST_READY;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        ST_READY: begin
          clr_cnt_q <= '0;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  // configuration registers, taken at any time including the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_RESET;
      grid_height_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_clear_q <= '0;
    end else if (eng_status.res_valid && res_take) begin
      out_valid_q <= 1'b1;
      out_clear_q <= eng_clearance;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - CLEAR_W)'(0), out_clear_q};

endmodule

`default_nettype wire

// File: hw/rtl/gsc_checker.sv
// port-level checker for the grid square clearance block and its bind
`default_nettype none

module gsc_checker import gsc_pkg::*; #(
  parameter int MAX_CLEARANCE = 8
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CAP = (MAX_CLEARANCE > CLEAR_SAT) ? CLEAR_SAT : MAX_CLEARANCE;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // the clearance never exceeds the cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CLEAR_W-1:0] <= CLEAR_W'(CAP))
    else $error("clearance above cap");

  // no item produces a result in the very next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without search time");

  // a query keeps the input closed while it runs
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
    else $error("item accepted during a query");

endmodule

bind grid_square_clearance gsc_checker #(.MAX_CLEARANCE(MAX_CLEARANCE)) u_gsc_checker (.*);

`default_nettype wire

// File: sim/tb_grid_square_clearance.sv
// self-checking testbench of grid_square_clearance: directed table, then random phases
module tb_grid_square_clearance;
  timeunit 1ns;
  timeprecision 1ps;
  import gsc_pkg::*;

  localparam int GRID_SIDE      = 64;
  localparam int MAX_CLEARANCE  = 8;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int IDLE_PCT       = 35;
  // the limit outlasts a whole query and the reset clearing pass of the map
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 66;
  localparam int QUIET_PHASE    = 4;
  localparam int DIR_ROWS       = 25;

  // clock and reset
  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // block ports, every input known from time zero
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // cell_x, cell_y, blocked_bit, zero pad
  logic                   s_axis_tuser  = KIND_WRITE;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // clearance, zero pad
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_index_i   = REG_GRID_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;

  grid_square_clearance #(
    .GRID_SIDE    (GRID_SIDE),
    .MAX_CLEARANCE(MAX_CLEARANCE)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: blocked map, registers and clearance search
  // ---------------------------------------------------------------------------
  bit               blocked_map [GRID_SIDE][GRID_SIDE];  // indexed [x][y]
  logic [CFG_W-1:0] width_reg  = CFG_RESET;
  logic [CFG_W-1:0] height_reg = CFG_RESET;

  // clearances still owed by the block, oldest first
  logic [CLEAR_W-1:0] clear_q [$];

  int err_cnt    = 0;
  int n_writes   = 0;
  int n_queries  = 0;
  int n_results  = 0;
  int n_zero     = 0;
  int n_capped   = 0;
  int n_settings = 0;
  bit no_idle    = 1'b0;  // set during the full-rate stretch

  // a register above the map side is clipped to the side
  function automatic int bound_of(logic [CFG_W-1:0] r);
    return (int'(r) < GRID_SIDE) ? int'(r) : GRID_SIDE;
  endfunction

  function automatic bit in_grid(int x, int y);
    return x < bound_of(width_reg) && y < bound_of(height_reg);
  endfunction

  // cells off the grid count as blocked
  function automatic bit cell_shut(int x, int y);
    if (!in_grid(x, y)) return 1'b1;
    return blocked_map[x][y];
  endfunction

  // grow the square ring by ring until a shut cell or the cap
  function automatic logic [CLEAR_W-1:0] clearance_of(int cx, int cy);
    int c;
    bit hit;
    if (cell_shut(cx, cy)) return '0;
    c = 1;
    while (c < MAX_CLEARANCE) begin
      hit = 1'b0;
      for (int i = 0; i <= c; i++) begin
        if (cell_shut(cx + i, cy + c) || cell_shut(cx + c, cy + i)) hit = 1'b1;
      end
      if (hit) break;
      c++;
    end
    if (c > CLEAR_SAT) c = CLEAR_SAT;
    return c[CLEAR_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // offer one item, wait for the handshake, then update the shadow
  task automatic push_item(kind_e kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic blk, bit typed, logic [CLEAR_W-1:0] typed_clear);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, blk, y, x};
    do @(posedge clk); while (!s_axis_tready);
    // the map changes at the accept edge, a query sees the map as of that edge
    if (kind == KIND_WRITE) begin
      n_writes++;
      if (in_grid(x, y)) blocked_map[x][y] = blk;
    end else begin
      n_queries++;
      clear_q = {clear_q, (typed ? typed_clear : clearance_of(x, y))};
    end
    @(negedge clk);
  endtask

  // registers change only with the block idle: no result owed and the pipe drained
  task automatic program_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    s_axis_tvalid <= 1'b0;
    while (clear_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_WIDTH;
    cfg_wdata_i <= w;
    @(negedge clk);
    cfg_index_i <= REG_GRID_HEIGHT;
    cfg_wdata_i <= h;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    width_reg  = w;
    height_reg = h;
    n_settings++;
  endtask

  // result side stalls at random except in the full-rate stretch
  always @(negedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    logic [CLEAR_W-1:0] want;
    logic [CLEAR_W-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[CLEAR_W-1:0];
      if (clear_q.size() == 0) begin
        report_mismatch($sformatf("clearance %0d with no query pending", got));
      end else begin
        want = clear_q.pop_front();
        n_results++;
        if (got == 0) n_zero++;
        if (got == MAX_CLEARANCE) n_capped++;
        if (got !== want)
          report_mismatch($sformatf("clearance got %0d want %0d", got, want));
      end
    end
  end

  // watchdog on cycles without any handshake on either side
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d clearances owed",
               stuck_cycles, clear_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table: expected clearance typed in where obvious, else shadow
  // ---------------------------------------------------------------------------
  typedef enum bit {ROW_ITEM, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e            op;
    kind_e              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               blk;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    bit                 typed;
    logic [CLEAR_W-1:0] clear;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty map after reset: origin reaches the cap, far corner stops at 1
    '{ROW_ITEM, KIND_QUERY, 6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 4'd8},
    '{ROW_ITEM, KIND_QUERY, 6'd63, 6'd63, 1'b0, 7'd0,   7'd0,   1'b1, 4'd1},
    '{ROW_ITEM, KIND_QUERY, 6'd60, 6'd10, 1'b0, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd0,  6'd63, 1'b0, 7'd0,   7'd0,   1'b1, 4'd1},
    // blocked cell answers 0, blocked_bit of a query is ignored
    '{ROW_ITEM, KIND_WRITE, 6'd5,  6'd5,  1'b1, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd5,  6'd5,  1'b0, 7'd0,   7'd0,   1'b1, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd5,  6'd5,  1'b1, 7'd0,   7'd0,   1'b1, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd4,  6'd4,  1'b0, 7'd0,   7'd0,   1'b0, 4'd0},
    // freeing the cell again restores the full square
    '{ROW_ITEM, KIND_WRITE, 6'd5,  6'd5,  1'b0, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd4,  6'd4,  1'b0, 7'd0,   7'd0,   1'b1, 4'd8},
    '{ROW_ITEM, KIND_WRITE, 6'd63, 6'd63, 1'b1, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd63, 6'd63, 1'b0, 7'd0,   7'd0,   1'b1, 4'd0},
    // zero width: every cell out, writes dropped
    '{ROW_CFG,  KIND_WRITE, 6'd0,  6'd0,  1'b0, 7'd0,   7'd64,  1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd0,  6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 4'd0},
    '{ROW_ITEM, KIND_WRITE, 6'd1,  6'd1,  1'b1, 7'd0,   7'd0,   1'b0, 4'd0},
    // registers above the side clip to it; the dropped write left (1,1) free
    '{ROW_CFG,  KIND_WRITE, 6'd0,  6'd0,  1'b0, 7'd127, 7'd127, 1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd1,  6'd1,  1'b0, 7'd0,   7'd0,   1'b1, 4'd8},
    // narrow grid: growth stops at the right and top edges
    '{ROW_CFG,  KIND_WRITE, 6'd0,  6'd0,  1'b0, 7'd10,  7'd3,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd8,  6'd0,  1'b0, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd9,  6'd2,  1'b0, 7'd0,   7'd0,   1'b1, 4'd1},
    '{ROW_ITEM, KIND_WRITE, 6'd12, 6'd1,  1'b1, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd10, 6'd0,  1'b0, 7'd0,   7'd0,   1'b1, 4'd0},
    // back to full size: the write beyond the edge must not have landed
    '{ROW_CFG,  KIND_WRITE, 6'd0,  6'd0,  1'b0, 7'd64,  7'd64,  1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd12, 6'd1,  1'b0, 7'd0,   7'd0,   1'b0, 4'd0},
    '{ROW_ITEM, KIND_QUERY, 6'd62, 6'd62, 1'b0, 7'd0,   7'd0,   1'b0, 4'd0}
  };

  // register settings of the random phases; phase 6 takes a random width and height instead
  logic [CFG_W-1:0] phase_w [NUM_PHASES] = '{7'd64, 7'd1, 7'd40, 7'd127,
                                             7'd64, 7'd20, 7'd0, 7'd64};
  logic [CFG_W-1:0] phase_h [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127,
                                             7'd64, 7'd64, 7'd0, 7'd9};

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                 bx;
    int                 by;
    int                 sel;
    kind_e              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               blk;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG)
        program_grid(dir_rows[i].w, dir_rows[i].h);
      else
        push_item(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y, dir_rows[i].blk,
                  dir_rows[i].typed, dir_rows[i].clear);
    end

    // random phases: a small window of cells gets painted and probed so the
    // squares run into blocked cells and grid edges, with some scattered items
    bx = 0;
    by = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = phase_w[p];
      h = phase_h[p];
      if (p == 6) begin
        w = CFG_W'($urandom_range(0, 127));
        h = CFG_W'($urandom_range(0, 127));
      end
      program_grid(w, h);
      no_idle = (p == QUIET_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) begin
          // move the window: anywhere, against the far edges, or at the origin
          sel = $urandom_range(0, 3);
          if (sel < 2) begin
            bx = $urandom_range(0, 63);
            by = $urandom_range(0, 63);
          end else if (sel == 2) begin
            bx = (bound_of(width_reg) > 8) ? bound_of(width_reg) - 8 : 0;
            by = (bound_of(height_reg) > 8) ? bound_of(height_reg) - 8 : 0;
          end else begin
            bx = 0;
            by = 0;
          end
        end
        kind = ($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_QUERY;
        if ($urandom_range(0, 99) < 75) begin
          x = COORD_W'((bx + $urandom_range(0, 11)) % GRID_SIDE);
          y = COORD_W'((by + $urandom_range(0, 11)) % GRID_SIDE);
        end else begin
          x = COORD_W'($urandom_range(0, 63));
          y = COORD_W'($urandom_range(0, 63));
        end
        blk = ($urandom_range(0, 99) < 35);
        push_item(kind, x, y, blk, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // drain: all clearances back, then let the block settle
    s_axis_tvalid <= 1'b0;
    while (clear_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d writes and %0d queries over %0d register settings",
             n_writes, n_queries, n_settings);
    $display("checked %0d clearances: %0d zero, %0d at the cap, %0d mismatches",
             n_results, n_zero, n_capped, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
